/* rtl/lfsc_pkg.sv */
package lfsc_pkg;

    localparam int unsigned CNT_W    = 35;
    localparam int unsigned HDR_WORDS = 6;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    localparam logic [31:0] EXP_VERSION_RST = 32'd1;
    localparam logic [15:0] MAX_DIM_RST     = 16'd16384;
    localparam logic [23:0] MAX_META_RST    = 24'h10_0000;

    typedef enum logic [1:0] {
        REG_EXP_VERSION = 2'd0,
        REG_MAX_DIM     = 2'd1,
        REG_MAX_META    = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        PH_MAGIC  = 3'd0,
        PH_HEADER = 3'd1,
        PH_META   = 3'd2,
        PH_MAPS   = 3'd3,
        PH_CRC    = 3'd4,
        PH_DRAIN  = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_MAGIC = 3'd1,
        ST_SHORT_HDR = 3'd2,
        ST_BAD_VER   = 3'd3,
        ST_BAD_DIMS  = 3'd4,
        ST_SHORT_META = 3'd5,
        ST_SHORT_MAP = 3'd6,
        ST_CRC_ERR   = 3'd7
    } status_t;

    typedef struct packed {
        logic [31:0] expected_version;
        logic [15:0] max_dimension;
        logic [23:0] max_meta_length;
    } cfg_t;

    typedef struct packed {
        logic        valid;
        status_t     status;
        logic [31:0] table_width;
        logic [31:0] table_height;
        logic [31:0] source_width;
        logic [31:0] source_height;
        logic [31:0] meta_length;
    } verdict_t;

    typedef struct packed {
        logic update;
        logic clear;
    } crc_ctl_t;

    function automatic logic [7:0] magic_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h41;
            3'd1:    b = 8'h56;
            3'd2:    b = 8'h4D;
            3'd3:    b = 8'h4C;
            3'd4:    b = 8'h55;
            3'd5:    b = 8'h54;
            3'd6:    b = 8'h30;
            default: b = 8'h31;
        endcase
        return b;
    endfunction

    // reflected crc-32, one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

endpackage

/* rtl/lfsc_crc.sv */
module lfsc_crc (
    input  logic              aclk,
    input  logic              aresetn,
    input  lfsc_pkg::crc_ctl_t ctl,
    input  logic [7:0]        data_byte,
    output logic [31:0]       crc
);

    logic [31:0] crc_reg;
    logic [31:0] crc_next;

    always_comb begin
        crc_next = crc_reg;
        if (ctl.clear) begin
            crc_next = lfsc_pkg::CRC_INIT;
        end else if (ctl.update) begin
            crc_next = lfsc_pkg::crc_byte(crc_reg, data_byte);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= lfsc_pkg::CRC_INIT;
        end else begin
            crc_reg <= crc_next;
        end
    end

    assign crc = crc_reg;

endmodule

/* rtl/lfsc_parse.sv */
module lfsc_parse (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_fire,
    input  logic [7:0]         data_byte,
    input  logic               last_byte,
    input  lfsc_pkg::cfg_t     cfg,
    input  logic [31:0]        crc,
    output lfsc_pkg::crc_ctl_t crc_ctl,
    output lfsc_pkg::verdict_t verdict
);

    localparam int unsigned CW = lfsc_pkg::CNT_W;

    lfsc_pkg::phase_t phase_reg, phase_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [31:0]      word_reg, word_next;
    logic [31:0]      hdr_reg  [lfsc_pkg::HDR_WORDS];
    logic [31:0]      hdr_next [lfsc_pkg::HDR_WORDS];
    logic [CW-1:0]    map_need_reg;

    logic [CW-1:0]    cnt_inc;
    logic [31:0]      word_shift;
    logic             give;
    lfsc_pkg::status_t status;
    logic             restart;
    logic             dims_bad;

    assign cnt_inc    = cnt_reg + CW'(1);
    assign word_shift = {data_byte, word_reg[31:8]};

    // the metadata length word completes on the last header byte itself
    assign dims_bad = (hdr_reg[1] == 32'd0) || (hdr_reg[2] == 32'd0) ||
                      (hdr_reg[1] > {16'd0, cfg.max_dimension}) ||
                      (hdr_reg[2] > {16'd0, cfg.max_dimension}) ||
                      (word_shift > {8'd0, cfg.max_meta_length});

    always_comb begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        word_next  = word_reg;
        for (int i = 0; i < lfsc_pkg::HDR_WORDS; i++) begin
            hdr_next[i] = hdr_reg[i];
        end
        give    = 1'b0;
        status  = lfsc_pkg::ST_OK;
        restart = 1'b0;
        crc_ctl = '0;

        if (in_fire) begin
            case (phase_reg)
                lfsc_pkg::PH_MAGIC: begin
                    crc_ctl.update = 1'b1;
                    if (data_byte != lfsc_pkg::magic_byte(cnt_reg[2:0])) begin
                        give   = 1'b1;
                        status = lfsc_pkg::ST_BAD_MAGIC;
                    end else if (cnt_reg[2:0] == 3'd7) begin
                        phase_next = lfsc_pkg::PH_HEADER;
                        cnt_next   = '0;
                        word_next  = '0;
                        if (last_byte) begin
                            give   = 1'b1;
                            status = lfsc_pkg::ST_SHORT_HDR;
                        end
                    end else begin
                        cnt_next = cnt_inc;
                        if (last_byte) begin
                            give   = 1'b1;
                            status = lfsc_pkg::ST_BAD_MAGIC;
                        end
                    end
                end
                lfsc_pkg::PH_HEADER: begin
                    crc_ctl.update = 1'b1;
                    word_next = word_shift;
                    cnt_next  = cnt_inc;
                    if (cnt_reg[1:0] == 2'd3) begin
                        for (int i = 0; i < lfsc_pkg::HDR_WORDS; i++) begin
                            if (cnt_reg[4:2] == 3'(i)) begin
                                hdr_next[i] = word_shift;
                            end
                        end
                        word_next = '0;
                    end
                    if (cnt_reg[4:0] == 5'd23) begin
                        cnt_next = '0;
                        if (hdr_reg[0] != cfg.expected_version) begin
                            give   = 1'b1;
                            status = lfsc_pkg::ST_BAD_VER;
                        end else if (dims_bad) begin
                            give   = 1'b1;
                            status = lfsc_pkg::ST_BAD_DIMS;
                        end else if (word_shift == 32'd0) begin
                            phase_next = lfsc_pkg::PH_MAPS;
                            give       = last_byte;
                            status     = lfsc_pkg::ST_SHORT_MAP;
                        end else begin
                            phase_next = lfsc_pkg::PH_META;
                            give       = last_byte;
                            status     = lfsc_pkg::ST_SHORT_META;
                        end
                    end else if (last_byte) begin
                        give   = 1'b1;
                        status = lfsc_pkg::ST_SHORT_HDR;
                    end
                end
                lfsc_pkg::PH_META: begin
                    crc_ctl.update = 1'b1;
                    cnt_next = cnt_inc;
                    if (cnt_inc >= {3'd0, hdr_reg[5]}) begin
                        phase_next = lfsc_pkg::PH_MAPS;
                        cnt_next   = '0;
                        give       = last_byte;
                        status     = lfsc_pkg::ST_SHORT_MAP;
                    end else begin
                        give   = last_byte;
                        status = lfsc_pkg::ST_SHORT_META;
                    end
                end
                lfsc_pkg::PH_MAPS: begin
                    crc_ctl.update = 1'b1;
                    cnt_next = cnt_inc;
                    if (cnt_inc >= map_need_reg) begin
                        phase_next = lfsc_pkg::PH_CRC;
                        cnt_next   = '0;
                        word_next  = '0;
                        give       = last_byte;
                        status     = lfsc_pkg::ST_CRC_ERR;
                    end else begin
                        give   = last_byte;
                        status = lfsc_pkg::ST_SHORT_MAP;
                    end
                end
                lfsc_pkg::PH_CRC: begin
                    word_next = word_shift;
                    cnt_next  = cnt_inc;
                    if (cnt_reg[1:0] == 2'd3) begin
                        give   = 1'b1;
                        status = (word_shift == ~crc) ? lfsc_pkg::ST_OK
                                                      : lfsc_pkg::ST_CRC_ERR;
                    end else begin
                        give   = last_byte;
                        status = lfsc_pkg::ST_CRC_ERR;
                    end
                end
                default: begin
                    restart = last_byte;
                end
            endcase

            if (give) begin
                if (last_byte) begin
                    restart = 1'b1;
                end else begin
                    phase_next = lfsc_pkg::PH_DRAIN;
                end
            end
        end

        // fields show the header as it stands after this byte
        verdict.valid         = give;
        verdict.status        = status;
        verdict.table_width   = hdr_next[1];
        verdict.table_height  = hdr_next[2];
        verdict.source_width  = hdr_next[3];
        verdict.source_height = hdr_next[4];
        verdict.meta_length   = hdr_next[5];

        if (restart) begin
            phase_next = lfsc_pkg::PH_MAGIC;
            cnt_next   = '0;
            word_next  = '0;
            for (int i = 0; i < lfsc_pkg::HDR_WORDS; i++) begin
                hdr_next[i] = '0;
            end
            crc_ctl.clear = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= lfsc_pkg::PH_MAGIC;
            cnt_reg   <= '0;
            word_reg  <= '0;
            for (int i = 0; i < lfsc_pkg::HDR_WORDS; i++) begin
                hdr_reg[i] <= '0;
            end
        end else begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            word_reg  <= word_next;
            for (int i = 0; i < lfsc_pkg::HDR_WORDS; i++) begin
                hdr_reg[i] <= hdr_next[i];
            end
        end
    end

    // map size follows the stored width and height while the header is read;
    // only the low halves matter once the dimension check has passed
    always_ff @(posedge aclk) begin
        if (phase_reg == lfsc_pkg::PH_HEADER) begin
            map_need_reg <= {32'(hdr_reg[1][15:0]) * 32'(hdr_reg[2][15:0]), 3'b000};
        end
    end

endmodule

/* rtl/lut_file_stream_checker_top.sv */
// channel   ports                          direction  payload
// request   s_valid/s_ready                in         s_data_byte, s_last_byte
// verdict   m_valid/m_ready                out        m_status, m_table_width, m_table_height,
//                                                     m_source_width, m_source_height,
//                                                     m_meta_length
// config    cfg_wr_en/cfg_index/cfg_wdata  in         32-bit register write
//
// one byte per cycle while s_ready is high; m_valid rises the cycle after the deciding byte
// the map size product is registered during the header, so the byte loop is
// one crc update plus one 35-bit count compare
// s_ready drops only while a verdict is held in the output register and m_ready is low
// aresetn (synchronous) restores register defaults and restarts at the magic

module lut_file_stream_checker_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [31:0] m_table_width,
    output logic [31:0] m_table_height,
    output logic [31:0] m_source_width,
    output logic [31:0] m_source_height,
    output logic [31:0] m_meta_length,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);

    lfsc_pkg::cfg_t     cfg_reg, cfg_next;
    lfsc_pkg::verdict_t verdict;
    lfsc_pkg::verdict_t out_reg, out_next;
    lfsc_pkg::crc_ctl_t crc_ctl;
    logic [31:0]        crc;
    logic               in_fire;

    assign s_ready = !out_reg.valid || m_ready;
    assign in_fire = s_valid && s_ready;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                lfsc_pkg::REG_EXP_VERSION: cfg_next.expected_version = cfg_wdata;
                lfsc_pkg::REG_MAX_DIM:     cfg_next.max_dimension    = cfg_wdata[15:0];
                lfsc_pkg::REG_MAX_META:    cfg_next.max_meta_length  = cfg_wdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        out_next = out_reg;
        if (verdict.valid) begin
            out_next = verdict;
        end else if (m_ready) begin
            out_next.valid = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.expected_version <= lfsc_pkg::EXP_VERSION_RST;
            cfg_reg.max_dimension    <= lfsc_pkg::MAX_DIM_RST;
            cfg_reg.max_meta_length  <= lfsc_pkg::MAX_META_RST;
            out_reg.valid            <= 1'b0;
        end else begin
            cfg_reg       <= cfg_next;
            out_reg.valid <= out_next.valid;
        end
        out_reg.status        <= out_next.status;
        out_reg.table_width   <= out_next.table_width;
        out_reg.table_height  <= out_next.table_height;
        out_reg.source_width  <= out_next.source_width;
        out_reg.source_height <= out_next.source_height;
        out_reg.meta_length   <= out_next.meta_length;
    end

    lfsc_crc u_crc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (crc_ctl),
        .data_byte (s_data_byte),
        .crc       (crc)
    );

    lfsc_parse u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .data_byte (s_data_byte),
        .last_byte (s_last_byte),
        .cfg       (cfg_reg),
        .crc       (crc),
        .crc_ctl   (crc_ctl),
        .verdict   (verdict)
    );

    assign m_valid         = out_reg.valid;
    assign m_status        = out_reg.status;
    assign m_table_width   = out_reg.table_width;
    assign m_table_height  = out_reg.table_height;
    assign m_source_width  = out_reg.source_width;
    assign m_source_height = out_reg.source_height;
    assign m_meta_length   = out_reg.meta_length;

endmodule
